// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the address filter core RTL
// Immediate-implication and next-cycle-implication property checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AAF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the following cycle
`define AAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/aaf_pkg.sv =====
// ---------------------------------------------------------------------------
// aaf_pkg
// Shared types and constants of the accepted address filter.
// ---------------------------------------------------------------------------
package aaf_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 4;
   localparam int unsigned ADDRESS_BYTES_DEF = 2;
   localparam int unsigned OPCODE_W          = 2;

   // request opcodes; the fourth code is a no-op
   typedef enum logic [OPCODE_W-1:0] {
      OP_CHECK = 2'd0,
      OP_ADD   = 2'd1,
      OP_PURGE = 2'd2
   } opcode_type;

   // status that travels with a request down the cell chain
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                hit;       // matched a valid slot upstream
      logic                placed;    // add already stored upstream
      logic                own_match; // equals own address
      logic                bcast;     // all-ones address
   } token_type;

endpackage

// ===== rtl/aaf_cell.sv =====
// ---------------------------------------------------------------------------
// aaf_cell
// One table slot: compares, stores or clears as a request beat passes by,
// then registers the beat for the next cell.
// ---------------------------------------------------------------------------
module aaf_cell #(
   parameter int unsigned ADDR_W = 8 * aaf_pkg::ADDRESS_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  aaf_pkg::token_type in_tok,
   input  logic [ADDR_W-1:0]  in_addr,
   output logic               out_valid,
   output aaf_pkg::token_type out_tok,
   output logic [ADDR_W-1:0]  out_addr
);

   logic               slot_valid_ff, slot_valid_in;
   logic [ADDR_W-1:0]  slot_addr_ff;
   logic               slot_write;
   logic               out_valid_ff;
   aaf_pkg::token_type out_tok_ff, out_tok_in;
   logic [ADDR_W-1:0]  out_addr_ff;
   logic               match;

   assign match = slot_valid_ff && (slot_addr_ff == in_addr);

   // slot update and token update
   always_comb begin
      slot_valid_in = slot_valid_ff;
      slot_write    = 1'b0;
      out_tok_in    = in_tok;
      if (in_valid) begin
         case (in_tok.op)
            aaf_pkg::OP_CHECK: begin
               out_tok_in.hit = in_tok.hit | match;
            end
            aaf_pkg::OP_ADD: begin
               out_tok_in.hit = in_tok.hit | match;
               // valid slots form a prefix, so every slot upstream was compared
               if (!slot_valid_ff && !in_tok.hit && !in_tok.placed) begin
                  slot_valid_in     = 1'b1;
                  slot_write        = 1'b1;
                  out_tok_in.placed = 1'b1;
               end
            end
            aaf_pkg::OP_PURGE: begin
               slot_valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         slot_valid_ff <= slot_valid_in;
         out_valid_ff  <= in_valid;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         out_tok_ff  <= out_tok_in;
         out_addr_ff <= in_addr;
         if (slot_write) begin
            slot_addr_ff <= in_addr;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_tok   = out_tok_ff;
   assign out_addr  = out_addr_ff;

endmodule

// ===== rtl/accepted_address_filter_core.sv =====
// ---------------------------------------------------------------------------
// accepted_address_filter_core
// Own address plus a table of accepted addresses, held in a chain of slot
// cells that a request walks through.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    opcode, address
//  rsp      out        rsp_tvalid/tready    is_mine, in_table, is_broadcast_addr,
//                                           add_dropped
//  csr      in         csr_valid/ready      own_address
//
// A request enters cell 0 and moves one cell per cycle while the chain is
// not frozen; its response is registered when the beat leaves the last cell.
// One request is in the chain at a time, so a new request is taken only once
// the previous one has left the cell chain. A response waiting in the output
// register does not block acceptance; a stalled response only freezes the
// chain when the next one reaches the end. Reset is synchronous and empties
// the table. The csr port is always ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module accepted_address_filter_core #(
   parameter int unsigned TABLE_ENTRIES = aaf_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned ADDRESS_BYTES = aaf_pkg::ADDRESS_BYTES_DEF,
   localparam int unsigned ADDR_W = 8 * ADDRESS_BYTES,
   localparam int unsigned REQ_W  = ((aaf_pkg::OPCODE_W + ADDR_W + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   // request: opcode [1:0], address [ADDR_W+1:2], zero fill above
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,
   // response: is_mine [0], in_table [1], is_broadcast_addr [2],
   // add_dropped [3], zero fill above
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   // own address register
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ADDR_W-1:0] csr_data
);

   localparam int unsigned OP_LSB   = 0;
   localparam int unsigned ADDR_LSB = aaf_pkg::OPCODE_W;

   logic [ADDR_W-1:0]  own_ff;
   logic               busy_ff;
   logic               rsp_valid_ff;
   logic [3:0]         rsp_flags_ff, rsp_flags_in;
   logic               advance;
   logic               req_fire;
   logic [ADDR_W-1:0]  req_addr;
   logic [aaf_pkg::OPCODE_W-1:0] req_op;

   logic               chain_valid [TABLE_ENTRIES+1];
   aaf_pkg::token_type chain_tok   [TABLE_ENTRIES+1];
   logic [ADDR_W-1:0]  chain_addr  [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES-1:0] cell_valid_vec;

   aaf_pkg::token_type last_tok;
   logic               last_valid;
   logic               op_lookup;

   // input unpack
   assign req_op   = req_tdata[OP_LSB +: aaf_pkg::OPCODE_W];
   assign req_addr = req_tdata[ADDR_LSB +: ADDR_W];
   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // chain freezes only while a finished beat cannot enter the output register
   assign advance = !(last_valid && rsp_valid_ff && !rsp_tready);

   // head of the chain
   assign chain_valid[0] = req_fire;
   assign chain_addr[0]  = req_addr;
   assign chain_tok[0]   = '{op: req_op, hit: 1'b0, placed: 1'b0,
                             own_match: (req_addr == own_ff), bcast: &req_addr};

   // slot cells
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      aaf_cell #(
         .ADDR_W (ADDR_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[i]),
         .in_tok    (chain_tok[i]),
         .in_addr   (chain_addr[i]),
         .out_valid (chain_valid[i+1]),
         .out_tok   (chain_tok[i+1]),
         .out_addr  (chain_addr[i+1])
      );
      assign cell_valid_vec[i] = chain_valid[i+1];
   end

   assign last_valid = chain_valid[TABLE_ENTRIES];
   assign last_tok   = chain_tok[TABLE_ENTRIES];

   // response flags from the beat leaving the chain
   assign op_lookup = (last_tok.op == aaf_pkg::OP_CHECK) ||
                      (last_tok.op == aaf_pkg::OP_ADD);
   always_comb begin
      rsp_flags_in[0] = op_lookup && (last_tok.hit || last_tok.own_match);
      rsp_flags_in[1] = op_lookup && last_tok.hit;
      rsp_flags_in[2] = op_lookup && last_tok.bcast;
      rsp_flags_in[3] = (last_tok.op == aaf_pkg::OP_ADD) &&
                        !last_tok.hit && !last_tok.placed;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff       <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            own_ff <= csr_data;
         end
         if (req_fire) begin
            busy_ff <= 1'b1;
         end else if (advance && last_valid) begin
            busy_ff <= 1'b0;
         end
         if (advance && last_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (advance && last_valid) begin
         rsp_flags_ff <= rsp_flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_flags_ff};

   // checks
   `AAF_ASSERT_NOW(a_one_beat_in_chain, clock, reset, 1'b1, $onehot0(cell_valid_vec),
      "more than one request in the cell chain")
   `AAF_ASSERT_NOW(a_chain_implies_busy, clock, reset, |cell_valid_vec, busy_ff,
      "request in the chain while not busy")
   `AAF_ASSERT_NEXT(a_accept_sets_busy, clock, reset, req_fire, busy_ff || rsp_valid_ff,
      "accepted request left no trace")
   `AAF_ASSERT_NOW(a_table_hit_is_mine, clock, reset, rsp_valid_ff && rsp_flags_ff[1],
      rsp_flags_ff[0] && !rsp_flags_ff[3], "table hit without is_mine or with drop")

endmodule

// ===== verif/tb_accepted_address_filter_core.sv =====
// ---------------------------------------------------------------------------
// tb_accepted_address_filter_core
// Self-checking bench for the accepted address filter. A directed table walks
// the corner cases (reset state, own and broadcast hits, full table, purge,
// no-op), then phases of random check/add/purge/no-op traffic run over a
// small address pool so the table fills, hits and drops. Each own address
// write happens with the block drained. Every response beat is compared
// field by field against typed flags or an in-bench model of the slot table.
// ---------------------------------------------------------------------------
module tb_accepted_address_filter_core;

   localparam int unsigned OPCODE_W    = aaf_pkg::OPCODE_W;
   localparam int unsigned SLOT_COUNT  = aaf_pkg::TABLE_ENTRIES_DEF;
   localparam int unsigned ADDR_W      = 8 * aaf_pkg::ADDRESS_BYTES_DEF;
   localparam int unsigned REQ_W       = ((OPCODE_W + ADDR_W + 7) / 8) * 8;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASES      = 8;
   localparam int unsigned PHASE_BEATS = 60;
   localparam int unsigned POOL_SIZE   = 6;
   localparam int unsigned MAX_REPORTS = 10;

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_CHECK = aaf_pkg::OP_CHECK;
   localparam logic [OPCODE_W-1:0] OP_ADD   = aaf_pkg::OP_ADD;
   localparam logic [OPCODE_W-1:0] OP_PURGE = aaf_pkg::OP_PURGE;
   // fourth opcode: the block does nothing and answers all zeros
   localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;
   localparam logic [ADDR_W-1:0]   ADDR_BCAST = '1;

   // response flags, lowest bit first: is_mine, in_table, bcast, dropped
   typedef struct packed {
      logic dropped;
      logic bcast;
      logic in_table;
      logic mine;
   } filter_flags_type;

   localparam filter_flags_type FLAGS_NONE       = 4'b0000;
   localparam filter_flags_type FLAGS_MINE       = 4'b0001;
   localparam filter_flags_type FLAGS_BCAST      = 4'b0100;
   localparam filter_flags_type FLAGS_MINE_BCAST = 4'b0101;

   // directed table rows: a request beat or an own address write
   localparam bit ROW_REQ = 1'b0;
   localparam bit ROW_OWN = 1'b1;
   localparam bit FROM_MODEL = 1'b0;
   localparam bit TYPED_IN   = 1'b1;

   typedef struct packed {
      logic                is_own_write;
      logic [OPCODE_W-1:0] op;
      logic [ADDR_W-1:0]   value;
      logic                typed;
      filter_flags_type    flags;
   } directed_row_type;

   localparam int unsigned DIRECTED_ROWS = 27;
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_REQ, OP_CHECK, 16'h0000, TYPED_IN,   FLAGS_MINE},       // own is zero after reset
      '{ROW_REQ, OP_CHECK, 16'hFFFF, TYPED_IN,   FLAGS_BCAST},
      '{ROW_REQ, OP_NOP,   16'hFFFF, TYPED_IN,   FLAGS_NONE},
      '{ROW_REQ, OP_PURGE, 16'hFFFF, TYPED_IN,   FLAGS_NONE},
      '{ROW_OWN, OP_CHECK, 16'h1234, FROM_MODEL, FLAGS_NONE},
      '{ROW_REQ, OP_CHECK, 16'h1234, TYPED_IN,   FLAGS_MINE},
      '{ROW_REQ, OP_CHECK, 16'h0000, TYPED_IN,   FLAGS_NONE},
      '{ROW_REQ, OP_ADD,   16'hFFFF, TYPED_IN,   FLAGS_BCAST},      // broadcast stored
      '{ROW_REQ, OP_ADD,   16'h1234, FROM_MODEL, FLAGS_NONE},       // own address stored
      '{ROW_REQ, OP_ADD,   16'h0000, FROM_MODEL, FLAGS_NONE},
      '{ROW_REQ, OP_ADD,   16'h00FF, FROM_MODEL, FLAGS_NONE},       // one byte of ones only
      '{ROW_REQ, OP_ADD,   16'hFF00, FROM_MODEL, FLAGS_NONE},       // table full, dropped
      '{ROW_REQ, OP_ADD,   16'h1234, FROM_MODEL, FLAGS_NONE},       // already present
      '{ROW_REQ, OP_CHECK, 16'hFFFF, FROM_MODEL, FLAGS_NONE},
      '{ROW_REQ, OP_CHECK, 16'hFF00, FROM_MODEL, FLAGS_NONE},
      '{ROW_REQ, OP_NOP,   16'h1234, TYPED_IN,   FLAGS_NONE},
      '{ROW_REQ, OP_PURGE, 16'h0000, TYPED_IN,   FLAGS_NONE},
      '{ROW_REQ, OP_CHECK, 16'h00FF, FROM_MODEL, FLAGS_NONE},
      '{ROW_OWN, OP_CHECK, 16'hFFFF, FROM_MODEL, FLAGS_NONE},
      '{ROW_REQ, OP_CHECK, 16'hFFFF, TYPED_IN,   FLAGS_MINE_BCAST}, // empty table
      '{ROW_REQ, OP_ADD,   16'h5555, FROM_MODEL, FLAGS_NONE},
      '{ROW_REQ, OP_ADD,   16'hAAAA, FROM_MODEL, FLAGS_NONE},
      '{ROW_REQ, OP_CHECK, 16'hAAAA, FROM_MODEL, FLAGS_NONE},
      '{ROW_OWN, OP_CHECK, 16'h0000, FROM_MODEL, FLAGS_NONE},
      '{ROW_REQ, OP_CHECK, 16'h0000, FROM_MODEL, FLAGS_NONE},
      '{ROW_REQ, OP_ADD,   16'hFFFF, FROM_MODEL, FLAGS_NONE},
      '{ROW_REQ, OP_PURGE, 16'hFFFF, FROM_MODEL, FLAGS_NONE}
   };

   // DUT ports
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [ADDR_W-1:0] csr_data = '0;

   // model of the slot table and own address
   logic [SLOT_COUNT-1:0] model_slot_valid = '0;
   logic [ADDR_W-1:0]     model_slot_addr [SLOT_COUNT];
   logic [ADDR_W-1:0]     model_own_addr = '0;

   filter_flags_type  pending_flags[$];
   int unsigned       error_count = 0;
   int unsigned       cycle_count = 0;
   bit                calm_stretch = 1'b0;
   int unsigned       rsp_hold = 0;
   logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

   accepted_address_filter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // flags the block should answer with; updates the table like the block does
   function automatic filter_flags_type filter_lookup(input logic [OPCODE_W-1:0] op,
                                                      input logic [ADDR_W-1:0] addr);
      filter_flags_type flags;
      logic             hit;
      int               free_slot;
      flags     = FLAGS_NONE;
      hit       = 1'b0;
      free_slot = -1;
      if (op == OP_CHECK || op == OP_ADD) begin
         for (int i = 0; i < SLOT_COUNT; i++)
            if (model_slot_valid[i] && model_slot_addr[i] == addr) hit = 1'b1;
         flags.in_table = hit;
         flags.mine     = hit || (addr == model_own_addr);
         flags.bcast    = (addr == ADDR_BCAST);
         if (op == OP_ADD && !hit) begin
            // lowest free slot wins
            for (int i = SLOT_COUNT - 1; i >= 0; i--)
               if (!model_slot_valid[i]) free_slot = i;
            if (free_slot >= 0) begin
               model_slot_valid[free_slot] = 1'b1;
               model_slot_addr[free_slot]  = addr;
            end else begin
               flags.dropped = 1'b1;
            end
         end
      end else if (op == OP_PURGE) begin
         model_slot_valid = '0;
      end
      return flags;
   endfunction

   function automatic int unsigned draw_pause();
      return calm_stretch ? 0 : $urandom_range(0, 15);
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_flag(input string name, input logic want, input logic got);
      if (got !== want) note_error($sformatf("%s expected %b got %b", name, want, got));
   endtask

   // one request beat; valid stays high after the handshake until the next call
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input bit typed, input filter_flags_type typed_flags);
      int unsigned      gap;
      filter_flags_type predicted;
      gap = draw_pause();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - OPCODE_W - ADDR_W){1'b0}}, addr, op};
      do @(posedge clock); while (!req_tready);
      predicted = filter_lookup(op, addr);
      pending_flags.push_back(typed ? typed_flags : predicted);
   endtask

   // stop sending and wait for every outstanding response
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
   endtask

   // own address write, only with the block drained
   task automatic write_own(input logic [ADDR_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      model_own_addr = value;
      csr_valid <= 1'b0;
   endtask

   // response side: random stalls, then compare each beat
   always @(posedge clock) begin
      int unsigned      stall;
      filter_flags_type want;
      filter_flags_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got = filter_flags_type'(rsp_tdata[3:0]);
         if (pending_flags.size() == 0) begin
            note_error($sformatf("response %h with nothing expected", rsp_tdata));
         end else begin
            want = pending_flags.pop_front();
            check_flag("is_mine", want.mine, got.mine);
            check_flag("in_table", want.in_table, got.in_table);
            check_flag("is_broadcast_addr", want.bcast, got.bcast);
            check_flag("add_dropped", want.dropped, got.dropped);
            if (rsp_tdata[7:4] !== 4'h0)
               note_error($sformatf("response fill bits %h", rsp_tdata[7:4]));
         end
         stall = draw_pause();
         rsp_tready <= (stall == 0);
         rsp_hold   <= stall;
      end else if (rsp_hold > 0) begin
         rsp_tready <= (rsp_hold == 1);
         rsp_hold   <= rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // stimulus
   initial begin
      logic [OPCODE_W-1:0] op;
      logic [ADDR_W-1:0]   addr;
      logic [ADDR_W-1:0]   own;
      int unsigned         pick;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_own_write == ROW_OWN)
            write_own(directed_rows[r].value);
         else
            send_request(directed_rows[r].op, directed_rows[r].value,
                         directed_rows[r].typed, directed_rows[r].flags);
      end

      // random phases: new own address and address pool per phase
      for (int phase = 0; phase < PHASES; phase++) begin
         foreach (addr_pool[i]) addr_pool[i] = ADDR_W'($urandom);
         if (phase % 4 == 1) addr_pool[0] = ADDR_BCAST;
         case (phase)
            0:       own = ADDR_BCAST;
            1:       own = '0;
            2:       own = addr_pool[1];
            default: own = ADDR_W'($urandom);
         endcase
         write_own(own);
         calm_stretch = (phase % 3 == 2);

         repeat (PHASE_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      op = OP_CHECK;
            else if (pick < 92) op = OP_ADD;
            else if (pick < 97) op = OP_PURGE;
            else                op = OP_NOP;

            pick = $urandom_range(0, 99);
            if (pick < 55)      addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick < 65) addr = model_own_addr;
            else if (pick < 72) addr = ADDR_BCAST;
            else if (pick < 76) addr = '0;
            else                addr = ADDR_W'($urandom);

            send_request(op, addr, FROM_MODEL, FLAGS_NONE);
         end
      end

      drain();
      repeat (SLOT_COUNT + 4) @(posedge clock);
      if (error_count == 0 && pending_flags.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
